[rtl/core/resident_cell_table_lru_evict_assert.svh]
// Assertion macros for the resident cell table.
`ifndef RESIDENT_CELL_TABLE_LRU_EVICT_ASSERT_SVH
`define RESIDENT_CELL_TABLE_LRU_EVICT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define RCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/rct_pkg.sv]
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants of the resident cell table.
// ----------------------------------------------------------------------------
package rct_pkg;
   localparam int Depth     = 64;
   localparam int IdxW      = $clog2(Depth);
   localparam int CntW      = 7;
   localparam int KeyW      = 32;
   localparam int GenW      = 32;
   localparam int FrameW    = 64;

   typedef enum logic [2:0] {
      KIND_UPSERT = 3'd0,
      KIND_TOUCH  = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_LOOKUP = 3'd3,
      KIND_TRIM   = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_SCAN,
      ST_EVICT,
      ST_OUT
   } state_type;

   // Command from sequencer to the cell row.
   typedef struct packed {
      logic              clear_all;  // drop every entry
      logic              write_en;   // write slot
      logic              write_new;  // also set key and valid
      logic              write_gen;
      logic              inval_en;   // drop slot
      logic [IdxW-1:0]   slot;
   } cell_cmd_type;

   typedef struct packed {
      logic [KeyW-1:0]   key;
      logic [GenW-1:0]   gen;
      logic [FrameW-1:0] frame;
   } entry_type;
endpackage

[rtl/core/rct_cell.sv]
// ----------------------------------------------------------------------------
// rct_cell
// One table slot; on a shift it takes over the contents of the cell after it.
// ----------------------------------------------------------------------------
module rct_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rct_pkg::cell_cmd_type cmd,
   input  logic                  sel,
   input  rct_pkg::entry_type    wr_data,
   input  logic                  shift,
   input  rct_pkg::entry_type    prev_entry,
   input  logic                  prev_valid,
   output rct_pkg::entry_type    entry,
   output logic                  valid
);
   import rct_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (shift) begin
         // rotate around the ring so the head cell sees every slot in turn
         entry_in = prev_entry;
         valid_in = prev_valid;
      end else if (cmd.clear_all) begin
         valid_in = 1'b0;
      end else if (sel && cmd.inval_en) begin
         valid_in = 1'b0;
      end else if (sel && cmd.write_en) begin
         entry_in.frame = wr_data.frame;
         if (cmd.write_gen) entry_in.gen = wr_data.gen;
         if (cmd.write_new) begin
            entry_in.key = wr_data.key;
            valid_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
endmodule

[rtl/core/rct_seq.sv]
// ----------------------------------------------------------------------------
// rct_seq
// Sequencer: walks the rotating cell row for key search and oldest scan.
// ----------------------------------------------------------------------------
module rct_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_go,
   input  rct_pkg::kind_type             in_kind,
   input  logic [rct_pkg::KeyW-1:0]      in_key,
   input  logic [rct_pkg::GenW-1:0]      in_gen,
   input  logic                          in_empty,
   input  logic [rct_pkg::CntW-1:0]      limit,
   input  rct_pkg::entry_type            head_entry,
   input  logic                          head_valid,
   output logic                          busy,
   output logic                          shift,
   output rct_pkg::cell_cmd_type         cmd,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          o_hit,
   output logic                          o_evicted,
   output logic [rct_pkg::KeyW-1:0]      o_evicted_key,
   output logic                          o_full,
   output logic [rct_pkg::CntW-1:0]      o_count,
   output logic                          o_last
);
   import rct_pkg::*;

   localparam logic [FrameW-1:0] FrameMax = '1;

   state_type         state_ff, state_in;
   logic [IdxW-1:0]   pos_ff, pos_in;      // slot id at the head
   logic [IdxW:0]     step_ff, step_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              hit_ff, hit_in;
   logic [IdxW-1:0]   hslot_ff, hslot_in;
   logic              gsame_ff, gsame_in;
   logic              free_ff, free_in;
   logic [IdxW-1:0]   fslot_ff, fslot_in;
   logic              old_ff, old_in;
   logic              more_ff, more_in;
   logic [IdxW-1:0]   oslot_ff, oslot_in;
   logic [FrameW-1:0] best_ff, best_in;
   logic [KeyW-1:0]   okey_ff, okey_in;
   logic              ev_ff, ev_in;
   logic [KeyW-1:0]   evk_ff, evk_in;
   logic              full_ff, full_in;
   logic              last_ff, last_in;
   logic              over;

   assign over = (limit != '0) && (count_ff > limit);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (in_go) state_in = ST_SEARCH;
         ST_SEARCH: if (step_ff == (IdxW+1)'(Depth - 1)) state_in = ST_APPLY;
         ST_APPLY: begin
            state_in = ST_OUT;
            if (in_kind == KIND_TRIM && over) state_in = ST_SCAN;
            if (in_kind == KIND_UPSERT && !(hit_ff && gsame_ff) && !in_empty
                && (hit_ff || free_ff)) state_in = ST_SCAN;
         end
         ST_SCAN:   if (step_ff == (IdxW+1)'(Depth - 1)) state_in = ST_EVICT;
         ST_EVICT:  state_in = ST_OUT;
         ST_OUT:    if (out_ready) state_in = last_ff ? ST_IDLE : ST_SCAN;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in = pos_ff; step_in = step_ff; count_in = count_ff;
      hit_in = hit_ff; hslot_in = hslot_ff; gsame_in = gsame_ff;
      free_in = free_ff; fslot_in = fslot_ff; old_in = old_ff; more_in = more_ff;
      oslot_in = oslot_ff; best_in = best_ff; okey_in = okey_ff;
      ev_in = ev_ff; evk_in = evk_ff; full_in = full_ff; last_in = last_ff;
      shift = 1'b0;
      cmd = '0;
      cmd.slot = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0; hit_in = 1'b0; free_in = 1'b0; gsame_in = 1'b0;
            ev_in = 1'b0; evk_in = '0; full_in = 1'b0;
         end
         ST_SEARCH: begin
            // first match and lowest free slot, one slot per cycle
            if (head_valid && head_entry.key == in_key && !hit_in) begin
               hit_in = 1'b1; hslot_in = pos_ff;
               gsame_in = head_entry.gen == in_gen;
            end
            if (!head_valid && !free_in) begin
               free_in = 1'b1; fslot_in = pos_ff;
            end
            shift = 1'b1; pos_in = pos_ff + 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == (IdxW+1)'(Depth - 1)) step_in = '0;
         end
         ST_APPLY: begin
            // head is back at slot 0, so slot id equals row position
            old_in = 1'b0; best_in = FrameMax; step_in = '0; last_in = 1'b1;
            unique case (in_kind)
               KIND_UPSERT: begin
                  if (hit_ff && gsame_ff) begin
                     cmd.write_en = 1'b1; cmd.slot = hslot_ff;
                  end else if (in_empty) begin
                     if (hit_ff) begin
                        cmd.inval_en = 1'b1; cmd.slot = hslot_ff;
                        count_in = count_ff - 1'b1;
                     end
                  end else if (hit_ff) begin
                     cmd.write_en = 1'b1; cmd.write_gen = 1'b1; cmd.slot = hslot_ff;
                  end else if (free_ff) begin
                     cmd.write_en = 1'b1; cmd.write_gen = 1'b1; cmd.write_new = 1'b1;
                     cmd.slot = fslot_ff; count_in = count_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               KIND_TOUCH: if (hit_ff) begin
                  cmd.write_en = 1'b1; cmd.slot = hslot_ff;
               end
               KIND_REMOVE: if (hit_ff) begin
                  cmd.inval_en = 1'b1; cmd.slot = hslot_ff;
                  count_in = count_ff - 1'b1;
               end
               KIND_CLEAR: begin
                  cmd.clear_all = 1'b1; count_in = '0;
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (step_ff == '0) begin
               old_in = 1'b0; best_in = FrameMax; more_in = 1'b0;
            end
            // a second evictable entry means another trim round can follow
            if (head_valid && head_entry.frame != FrameMax && old_in) more_in = 1'b1;
            if (head_valid && head_entry.frame < ((step_ff == '0) ? FrameMax : best_ff)) begin
               old_in = 1'b1; oslot_in = pos_ff;
               best_in = head_entry.frame; okey_in = head_entry.key;
            end
            shift = 1'b1; pos_in = pos_ff + 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == (IdxW+1)'(Depth - 1)) step_in = '0;
         end
         ST_EVICT: begin
            // pick up the trim decision: plain result if nothing to evict
            if (over && old_ff) begin
               cmd.inval_en = 1'b1; cmd.slot = oslot_ff;
               count_in = count_ff - 1'b1;
               ev_in = 1'b1; evk_in = okey_ff;
               last_in = !(more_ff && (limit != '0) && (count_ff - 1'b1 > limit));
            end else begin
               ev_in = 1'b0; evk_in = '0; last_in = 1'b1;
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
      hit_ff <= hit_in; hslot_ff <= hslot_in; gsame_ff <= gsame_in;
      free_ff <= free_in; fslot_ff <= fslot_in; old_ff <= old_in; more_ff <= more_in;
      oslot_ff <= oslot_in; best_ff <= best_in; okey_ff <= okey_in;
      ev_ff <= ev_in; evk_ff <= evk_in; full_ff <= full_in; last_ff <= last_in;
   end

   // A first eviction with nothing to evict falls back to the plain result;
   // a later one cannot happen since last would have been set.
   assign busy          = state_ff != ST_IDLE;
   assign out_valid     = state_ff == ST_OUT;
   assign o_hit         = hit_ff;
   assign o_evicted     = ev_ff;
   assign o_evicted_key = evk_ff;
   assign o_full        = full_ff;
   assign o_count       = count_ff;
   assign o_last        = last_ff;
endmodule

[rtl/core/resident_cell_table_lru_evict.sv]
// Sequence: an accepted request runs a key search over all slots, then an apply step;
// an upsert writing a new generation or a new entry, or an over-limit trim, adds an oldest scan and an evict step.
// One item at a time: no new request is accepted until the last result beat is taken;
// each further evicted entry repeats the scan and evict steps. The ring rotates one slot a cycle.
// Reset: synchronous; clears all valid bits, the count and the limit.
// ----------------------------------------------------------------------------
// resident_cell_table_lru_evict
// Keyed residency table with oldest-frame eviction on a rotating cell ring.
// ----------------------------------------------------------------------------
module resident_cell_table_lru_evict (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [2:0] kind, [34:3] cell_key, [66:35] generation, [130:67] frame,
   // [131] packet_empty, [135:132] zero
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] hit, [1] evicted, [33:2] evicted_key, [34] table_full,
   // [41:35] resident_count, [47:42] zero
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);
   import rct_pkg::*;
   `include "resident_cell_table_lru_evict_assert.svh"

   logic [CntW-1:0]   limit_ff;
   kind_type          kind_ff;
   logic [KeyW-1:0]   key_ff;
   logic              empty_ff;
   entry_type         wr_ff;
   logic              busy, shift, go;
   cell_cmd_type      cmd;
   entry_type         ent [Depth];
   logic              vld [Depth];
   logic              o_hit, o_ev, o_full, o_last;
   logic [KeyW-1:0]   o_evk;
   logic [CntW-1:0]   o_cnt;

   assign req_tready = !busy;
   assign go         = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= '0;
      else if (csr_valid) limit_ff <= csr_data;
      if (go) begin
         kind_ff        <= kind_type'(req_tdata[2:0]);
         key_ff         <= req_tdata[34:3];
         wr_ff.key      <= req_tdata[34:3];
         wr_ff.gen      <= req_tdata[66:35];
         wr_ff.frame    <= req_tdata[130:67];
         empty_ff       <= req_tdata[131];
      end
   end

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      rct_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .sel(cmd.slot == IdxW'(i)), .wr_data(wr_ff), .shift(shift),
         .prev_entry(ent[(i + 1) % Depth]), .prev_valid(vld[(i + 1) % Depth]),
         .entry(ent[i]), .valid(vld[i])
      );
   end

   rct_seq u_seq (
      .clock(clock), .reset(reset), .in_go(go), .in_kind(kind_ff),
      .in_key(key_ff), .in_gen(wr_ff.gen), .in_empty(empty_ff),
      .limit(limit_ff), .head_entry(ent[0]), .head_valid(vld[0]),
      .busy(busy), .shift(shift), .cmd(cmd), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .o_hit(o_hit), .o_evicted(o_ev),
      .o_evicted_key(o_evk), .o_full(o_full), .o_count(o_cnt), .o_last(o_last)
   );

   assign rsp_tdata = {6'd0, o_cnt, o_full, o_evk, o_ev, o_hit};
   assign rsp_tlast = o_last;

   `RCT_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "accept while result pending")
   `RCT_ASSERT_IMP(a_full_no_evict, clock, reset, rsp_tvalid && rsp_tdata[34], !rsp_tdata[1] && rsp_tlast, "full with eviction")
   `RCT_ASSERT_NXT(a_evict_drops, clock, reset, rsp_tvalid && rsp_tready && rsp_tdata[1] && !rsp_tlast, !rsp_tvalid, "eviction result repeated")
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams upsert, touch, remove, lookup, trim, clear and spare-kind beats into the
// resident cell table under several resident limits, mirrors the table in a
// behavioral copy, and checks every response beat against it in order.
// ----------------------------------------------------------------------------
module tb;
   import rct_pkg::*;

   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam int         KeyPool     = 72;
   localparam int         CycleLimit  = 20000000;
   localparam int         DrainCycles = 300;
   localparam logic [FrameW-1:0] FrameOnes = '1;

   typedef struct {
      logic [2:0]        kind;
      logic [KeyW-1:0]   key;
      logic [GenW-1:0]   gen;
      logic [FrameW-1:0] frame;
      logic              empty;
   } cmd_t;

   typedef struct {
      logic            hit;
      logic            evicted;
      logic [KeyW-1:0] evicted_key;
      logic            full;
      logic [6:0]      count;
      logic            last;
   } rsp_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [6:0]   csr_data;

   resident_cell_table_lru_evict dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // mirror of the table
   logic [KeyW-1:0]   mir_key   [Depth];
   logic [GenW-1:0]   mir_gen   [Depth];
   logic [FrameW-1:0] mir_frame [Depth];
   logic              mir_valid [Depth];
   int unsigned       mir_count;
   int unsigned       mir_limit;

   cmd_t        cmd_queue[$];
   rsp_t        rsp_expect[$];
   logic [KeyW-1:0] key_pool[KeyPool];
   logic [FrameW-1:0] frame_now;
   int          mismatches;
   int          cycles;
   int          req_gap;
   int          rsp_gap;
   int          hold_cycles;
   bit          hold_done;
   bit          no_idle;
   bit          req_taken;
   int          accepted_items;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic push_rsp(input logic hit, input logic ev, input logic [KeyW-1:0] k,
                           input logic full);
      rsp_t r;
      r.hit = hit;
      r.evicted = ev;
      r.evicted_key = ev ? k : '0;
      r.full = full;
      r.count = mir_count[6:0];
      r.last = 1'b0;
      rsp_expect.push_back(r);
   endtask

   // evict the oldest valid entry while over a nonzero limit
   task automatic trim_oldest(input logic hit);
      int oldest;
      logic [FrameW-1:0] best;
      if (mir_limit == 0) return;
      while (mir_count > mir_limit) begin
         oldest = -1;
         best = FrameOnes;
         for (int i = 0; i < Depth; i++)
            if (mir_valid[i] && mir_frame[i] < best) begin
               best = mir_frame[i];
               oldest = i;
            end
         if (oldest < 0) return;
         mir_valid[oldest] = 1'b0;
         mir_count--;
         push_rsp(hit, 1'b1, mir_key[oldest], 1'b0);
      end
   endtask

   task automatic apply_cmd(input cmd_t c);
      int slot;
      int start;
      logic hit;
      logic full;
      rsp_t r;
      slot = -1;
      full = 1'b0;
      start = rsp_expect.size();
      for (int i = 0; i < Depth; i++)
         if (slot < 0 && mir_valid[i] && mir_key[i] == c.key) slot = i;
      hit = (slot >= 0);
      case (c.kind)
         KIND_UPSERT: begin
            if (hit && mir_gen[slot] == c.gen) begin
               mir_frame[slot] = c.frame;
            end else if (c.empty) begin
               if (hit) begin
                  mir_valid[slot] = 1'b0;
                  mir_count--;
               end
            end else begin
               if (!hit) begin
                  for (int i = 0; i < Depth; i++)
                     if (slot < 0 && !mir_valid[i]) slot = i;
                  if (slot < 0) full = 1'b1;
                  else begin
                     mir_valid[slot] = 1'b1;
                     mir_key[slot] = c.key;
                     mir_count++;
                  end
               end
               if (!full) begin
                  mir_gen[slot] = c.gen;
                  mir_frame[slot] = c.frame;
                  trim_oldest(hit);
               end
            end
         end
         KIND_TOUCH: if (hit) mir_frame[slot] = c.frame;
         KIND_REMOVE: if (hit) begin
            mir_valid[slot] = 1'b0;
            mir_count--;
         end
         KIND_TRIM: trim_oldest(hit);
         KIND_CLEAR: begin
            for (int i = 0; i < Depth; i++) mir_valid[i] = 1'b0;
            mir_count = 0;
         end
         default: ;
      endcase
      if (rsp_expect.size() == start) push_rsp(hit, 1'b0, '0, full);
      r = rsp_expect[$];
      r.last = 1'b1;
      rsp_expect[$] = r;
   endtask

   // driver
   always @(negedge clock) begin
      cmd_t c;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (req_tvalid && !req_taken) begin
         // hold the beat
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
         c = cmd_queue.pop_front();
         req_tdata <= {4'b0, c.empty, c.frame, c.gen, c.key, c.kind};
         req_tvalid <= 1'b1;
         req_gap = pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_items >= 130) begin
         hold_done = 1'b1;
         hold_cycles = 3000;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // accept, predict and check
   always @(posedge clock) begin
      rsp_t e;
      cmd_t c;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         req_taken <= req_tvalid && req_tready && !reset;
         if (!reset && req_tvalid && req_tready) begin
            c.kind = req_tdata[2:0];
            c.key = req_tdata[34:3];
            c.gen = req_tdata[66:35];
            c.frame = req_tdata[130:67];
            c.empty = req_tdata[131];
            apply_cmd(c);
            accepted_items++;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (rsp_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               e = rsp_expect.pop_front();
               if (rsp_tdata[0] !== e.hit || rsp_tdata[1] !== e.evicted ||
                   rsp_tdata[33:2] !== e.evicted_key || rsp_tdata[34] !== e.full ||
                   rsp_tdata[41:35] !== e.count || rsp_tlast !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hit %b ev %b key %h full %b cnt %0d last %b;%s",
                              e.hit, e.evicted, e.evicted_key, e.full, e.count, e.last,
                              $sformatf(" got hit %b ev %b key %h full %b cnt %0d last %b",
                                        rsp_tdata[0], rsp_tdata[1], rsp_tdata[33:2],
                                        rsp_tdata[34], rsp_tdata[41:35], rsp_tlast));
               end
            end
         end
      end
   end

   function automatic cmd_t mk(input logic [2:0] kind, input logic [KeyW-1:0] key,
                               input logic [GenW-1:0] gen, input logic [FrameW-1:0] frame,
                               input logic empty);
      cmd_t c;
      c.kind = kind;
      c.key = key;
      c.gen = gen;
      c.frame = frame;
      c.empty = empty;
      return c;
   endfunction

   function automatic cmd_t rand_cmd(input int upsert_pct);
      cmd_t c;
      int r;
      r = $urandom_range(0, 99);
      if (r < upsert_pct) c.kind = KIND_UPSERT;
      else if (r < upsert_pct + 10) c.kind = KIND_TOUCH;
      else if (r < upsert_pct + 18) c.kind = KIND_REMOVE;
      else if (r < upsert_pct + 26) c.kind = KIND_LOOKUP;
      else if (r < upsert_pct + 33) c.kind = KIND_TRIM;
      else if (r < upsert_pct + 34) c.kind = KIND_CLEAR;
      else if (r < upsert_pct + 36) c.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      else c.kind = KIND_UPSERT;
      c.key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, KeyPool - 1)]
                                           : $urandom;
      c.gen = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2) : $urandom;
      r = $urandom_range(0, 99);
      frame_now += $urandom_range(0, 5);
      if (r < 70) c.frame = frame_now;
      else if (r < 85) c.frame = {$urandom, $urandom};
      else if (r < 93) c.frame = FrameOnes;
      else c.frame = '0;
      c.empty = ($urandom_range(0, 9) == 0);
      return c;
   endfunction

   task automatic settle(input int drain);
      while (cmd_queue.size() > 0 || req_tvalid || rsp_expect.size() > 0)
         @(posedge clock);
      repeat (drain) @(posedge clock);
   endtask

   task automatic write_limit(input logic [6:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mir_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic fill_store(input logic [FrameW-1:0] base, input bit pin_some);
      for (int i = 0; i < Depth; i++)
         cmd_queue.push_back(mk(KIND_UPSERT, key_pool[i], $urandom,
                                (pin_some && i % 16 == 5) ? FrameOnes
                                                          : base + $urandom_range(0, 40), 1'b0));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      mismatches = 0;
      cycles = 0;
      req_gap = 0;
      rsp_gap = 0;
      hold_cycles = 0;
      hold_done = 1'b0;
      no_idle = 1'b0;
      req_taken = 1'b0;
      accepted_items = 0;
      frame_now = 64'd100;
      mir_count = 0;
      mir_limit = 0;
      for (int i = 0; i < Depth; i++) mir_valid[i] = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KeyPool; i++) key_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every kind and corner against an unlimited table
      cmd_queue.push_back(mk(KIND_LOOKUP, '1, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_UPSERT, '1, '1, '1, 1'b0));
      cmd_queue.push_back(mk(KIND_UPSERT, '1, '1, 64'd5, 1'b1));
      cmd_queue.push_back(mk(KIND_UPSERT, '1, '0, 64'd6, 1'b0));
      cmd_queue.push_back(mk(KIND_LOOKUP, '1, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_UPSERT, '1, 32'd9, '0, 1'b1));
      cmd_queue.push_back(mk(KIND_UPSERT, '0, '0, '0, 1'b1));
      cmd_queue.push_back(mk(KIND_TOUCH, 32'h1234, '0, 64'd7, 1'b0));
      cmd_queue.push_back(mk(KIND_REMOVE, 32'h1234, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_UPSERT, '0, 32'hA5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 1'b0));
      cmd_queue.push_back(mk(KIND_TOUCH, '0, '0, 64'd8, 1'b0));
      cmd_queue.push_back(mk(KIND_TRIM, '0, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_SPARE6, '0, '1, '1, 1'b1));
      cmd_queue.push_back(mk(KIND_SPARE7, 32'h55, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_REMOVE, '0, '0, '0, 1'b0));
      cmd_queue.push_back(mk(KIND_CLEAR, '0, '0, '0, 1'b0));
      // fill, then overflow the store
      fill_store(64'd10, 1'b0);
      cmd_queue.push_back(mk(KIND_UPSERT, key_pool[70], 32'd1, 64'd3, 1'b0));
      cmd_queue.push_back(mk(KIND_UPSERT, 32'hDEADBEEF, 32'd1, 64'd3, 1'b0));
      cmd_queue.push_back(mk(KIND_CLEAR, '0, '0, '0, 1'b0));
      settle(DrainCycles);

      // limit at the top: never exceeded
      write_limit(7'd64);
      no_idle = 1'b1;
      repeat (50) cmd_queue.push_back(rand_cmd(60));
      settle(DrainCycles);
      no_idle = 1'b0;

      write_limit(7'd1);
      repeat (50) cmd_queue.push_back(rand_cmd(55));
      settle(DrainCycles);

      write_limit(7'd8);
      repeat (40) cmd_queue.push_back(rand_cmd(55));
      settle(DrainCycles);

      // full store, then a lowered limit applied by one trim
      write_limit(7'd0);
      cmd_queue.push_back(mk(KIND_CLEAR, '0, '0, '0, 1'b0));
      fill_store(64'd1000, 1'b1);
      settle(DrainCycles);
      write_limit(7'd3);
      cmd_queue.push_back(mk(KIND_TRIM, key_pool[5], '0, '0, 1'b0));
      settle(DrainCycles);

      // pause mid-phase until every response has come back
      write_limit(7'd20);
      repeat (40) cmd_queue.push_back(rand_cmd(60));
      settle(0);
      repeat (40) cmd_queue.push_back(rand_cmd(60));
      settle(DrainCycles);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
